// ===== rtl/core/iira_pkg.sv =====
// Shared types and constants for the indexed insert/remove record list.
package iira_pkg;

   localparam int POS_W    = 7;
   localparam int FILL_W   = 7;
   localparam int AMOUNT_W = 16;
   localparam int CARD_W   = 54;

   typedef enum logic [2:0] {
      OP_GET       = 3'd0,
      OP_INSERT    = 3'd1,
      OP_REMOVE    = 3'd2,
      OP_APPEND    = 3'd3,
      OP_PREPEND   = 3'd4,
      OP_POP_LAST  = 3'd5,
      OP_POP_FIRST = 3'd6,
      OP_CLEAR     = 3'd7
   } req_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [AMOUNT_W-1:0] amount;
      logic [CARD_W-1:0]   card;
      logic                available;
   } record_type;

   localparam int REC_W = $bits(record_type);

   // controller to datapath
   typedef struct packed {
      logic latch;     // take the request word
      logic check;     // record the status of the request
      logic rd_take;   // read the entry to be returned
      logic cap_take;  // capture that entry
      logic sh_init;   // load the shift cursor
      logic sh_rd;     // read the shift source
      logic sh_wr;     // write the shift destination, step the cursor
      logic put;       // write the new record, count up
      logic dec;       // count down
      logic clr;       // empty the list
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      req_op_type op;
      status_type err;
      logic       sh_more;
   } dp_stat_type;

endpackage

// ===== rtl/core/iira_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iira_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/iira_ctrl.sv =====
// Request sequencer: decodes the request and steps the datapath through it.
module iira_ctrl import iira_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_TAKE,
      S_SHIFT_RD,
      S_SHIFT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      finish;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      finish   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.err != ST_OK) begin
               finish = 1'b1;
            end else begin
               unique case (stat.op) inside
                  OP_GET, OP_POP_LAST, OP_POP_FIRST: begin
                     cmd.rd_take = 1'b1;
                     state_in    = S_TAKE;
                  end
                  OP_INSERT, OP_PREPEND, OP_REMOVE: begin
                     cmd.sh_init = 1'b1;
                     state_in    = S_SHIFT_RD;
                  end
                  OP_APPEND: begin
                     cmd.put = 1'b1;
                     finish  = 1'b1;
                  end
                  default: begin
                     cmd.clr = 1'b1;
                     finish  = 1'b1;
                  end
               endcase
            end
         end
         S_TAKE: begin
            cmd.cap_take = 1'b1;
            unique case (stat.op) inside
               OP_POP_LAST: begin
                  cmd.dec = 1'b1;
                  finish  = 1'b1;
               end
               OP_POP_FIRST: begin
                  cmd.sh_init = 1'b1;
                  state_in    = S_SHIFT_RD;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (stat.sh_more) begin
               cmd.sh_rd = 1'b1;
               state_in  = S_SHIFT_WR;
            end else begin
               // gap open or closed: finish the request
               unique case (stat.op) inside
                  OP_INSERT, OP_PREPEND: cmd.put = 1'b1;
                  default:               cmd.dec = 1'b1;
               endcase
               finish = 1'b1;
            end
         end
         S_SHIFT_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= finish;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && state_ff == S_IDLE)
      else $error("result strobe while a request is in flight");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_CHECK && busy)
      else $error("accepted word did not reach the check state");

endmodule

// ===== rtl/core/iira_dpath.sv =====
// Datapath: request registers, fill count, shift cursor and record RAM.
module iira_dpath import iira_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         stat,
   input  logic [2:0]          req_type,
   input  logic [POS_W-1:0]    req_position,
   input  logic [AMOUNT_W-1:0] req_in_amount,
   input  logic [CARD_W-1:0]   req_in_card,
   input  logic                req_in_available,
   output status_type          rsp_status,
   output logic [AMOUNT_W-1:0] rsp_out_amount,
   output logic [CARD_W-1:0]   rsp_out_card,
   output logic                rsp_out_available,
   output logic [FILL_W-1:0]   rsp_fill_count
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   req_op_type       op_ff, op_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   record_type       in_rec_ff, in_rec_in;
   record_type       res_ff, res_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    ptr_ff, ptr_in;

   logic             empty;
   logic             full;
   logic [CMPW-1:0]  pos_ext;
   logic [CMPW-1:0]  cnt_ext;
   logic             shift_up;
   status_type       err;
   logic [AW-1:0]    put_at;
   logic [AW-1:0]    take_at;
   logic [AW-1:0]    src;
   logic             sh_more;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [REC_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [REC_W-1:0] ram_rd_data;
   record_type       rd_rec;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff >= CW'(CAPACITY));
   assign pos_ext  = CMPW'(pos_ff);
   assign cnt_ext  = CMPW'(count_ff);
   assign shift_up = (op_ff == OP_INSERT) || (op_ff == OP_PREPEND);
   assign rd_rec   = record_type'(ram_rd_data);

   always_comb begin
      err = ST_OK;
      unique case (op_ff) inside
         OP_GET, OP_REMOVE: begin
            if (empty)                  err = ST_EMPTY;
            else if (pos_ext >= cnt_ext) err = ST_RANGE;
         end
         OP_INSERT: begin
            // index checked before fill
            if (pos_ext > cnt_ext) err = ST_RANGE;
            else if (full)         err = ST_FULL;
         end
         OP_APPEND, OP_PREPEND: begin
            if (full) err = ST_FULL;
         end
         OP_POP_LAST, OP_POP_FIRST: begin
            if (empty) err = ST_EMPTY;
         end
         default: begin
            err = ST_OK;
         end
      endcase
   end

   always_comb begin
      unique case (op_ff) inside
         OP_INSERT: put_at = AW'(pos_ff);
         OP_APPEND: put_at = AW'(count_ff);
         default:   put_at = '0;
      endcase
      unique case (op_ff) inside
         OP_GET:      take_at = AW'(pos_ff);
         OP_POP_LAST: take_at = AW'(count_ff - CW'(1));
         default:     take_at = '0;
      endcase
   end

   // up: dst runs from count down to put_at+1; down: dst runs from pos (0 for pop first) up to count-2
   assign src     = shift_up ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
   assign sh_more = shift_up ? (ptr_ff > put_at) : ((CW'(ptr_ff) + CW'(1)) < count_ff);

   assign stat.op      = op_ff;
   assign stat.err     = err;
   assign stat.sh_more = sh_more;

   always_comb begin
      op_in     = op_ff;
      pos_in    = pos_ff;
      in_rec_in = in_rec_ff;
      res_in    = res_ff;
      status_in = status_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      if (cmd.latch) begin
         op_in               = req_op_type'(req_type);
         pos_in              = req_position;
         in_rec_in.amount    = req_in_amount;
         in_rec_in.card      = req_in_card;
         in_rec_in.available = req_in_available;
         res_in              = '0;
      end
      if (cmd.check) begin
         status_in = err;
      end
      if (cmd.cap_take) begin
         res_in = rd_rec;
      end
      if (cmd.sh_init) begin
         if (shift_up)                ptr_in = AW'(count_ff);
         else if (op_ff == OP_REMOVE) ptr_in = AW'(pos_ff);
         else                         ptr_in = '0;
      end else if (cmd.sh_wr) begin
         ptr_in = src;
      end
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.put) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      in_rec_ff <= in_rec_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      ptr_ff    <= ptr_in;
   end

   assign ram_wr_en   = cmd.put | cmd.sh_wr;
   assign ram_wr_addr = cmd.put ? put_at : ptr_ff;
   assign ram_wr_data = cmd.put ? REC_W'(in_rec_ff) : ram_rd_data;
   assign ram_rd_en   = cmd.rd_take | cmd.sh_rd;
   assign ram_rd_addr = cmd.rd_take ? take_at : src;

   iira_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_status        = status_ff;
   assign rsp_out_amount    = res_ff.amount;
   assign rsp_out_card      = res_ff.card;
   assign rsp_out_available = res_ff.available;
   assign rsp_fill_count    = FILL_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_put_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> !full)
      else $error("record written into a full list");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.put && cmd.sh_wr) && !(cmd.rd_take && cmd.sh_rd))
      else $error("two sources on one RAM port");

endmodule

// ===== rtl/core/indexed_insert_remove_array.sv =====
// Steps to rsp_valid: append, clear and refused words end in the check state; get and
// pop last end in the take state; insert, prepend and remove shift; pop first takes and shifts.
// The record RAM moves each entry with a shift read, then a shift write, before the next entry.
// A new word is taken in the rsp_valid cycle, so the next word waits until the last one is through.
// Reset clears the fill count and the sequencer; the record RAM is not cleared.
// The receiver cannot stall: rsp_valid is high for one cycle only; rsp_ data holds until the next word.
module indexed_insert_remove_array import iira_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_type,
   input  logic [POS_W-1:0]    req_position,
   input  logic [AMOUNT_W-1:0] req_in_amount,
   input  logic [CARD_W-1:0]   req_in_card,
   input  logic                req_in_available,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [AMOUNT_W-1:0] rsp_out_amount,
   output logic [CARD_W-1:0]   rsp_out_card,
   output logic                rsp_out_available,
   output logic [FILL_W-1:0]   rsp_fill_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   status_type  status;

   iira_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   iira_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_in_amount     (req_in_amount),
      .req_in_card       (req_in_card),
      .req_in_available  (req_in_available),
      .rsp_status        (status),
      .rsp_out_amount    (rsp_out_amount),
      .rsp_out_card      (rsp_out_card),
      .rsp_out_available (rsp_out_available),
      .rsp_fill_count    (rsp_fill_count)
   );

   assign rsp_status = status;

endmodule
